// ----- sv/mhpq_pkg.sv -----
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and codes for the min-heap priority queue core.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    localparam int KEY_W     = 31;
    localparam int TAG_W     = 8;
    localparam int CNT_OUT_W = 7;
    localparam int STATUS_W  = 2;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_entry;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_LOAD,
        S_DOWN,
        S_PUT,
        S_DONE
    } t_state;

endpackage

// ----- sv/mhpq_mem.sv -----
// ----------------------------------------------------------------------------
// mhpq_mem
// Heap entry storage: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module mhpq_mem
    import mhpq_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output t_entry        o_rdata_a,
    output t_entry        o_rdata_b
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata_a;
    t_entry r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ----- sv/min_heap_priority_queue_core.sv -----
// ----------------------------------------------------------------------------
// min_heap_priority_queue_core
// Binary min-heap of (key, tag) entries with insert and remove-min requests.
// ----------------------------------------------------------------------------
// One request is worked at a time. An insert climbs the new entry one level per
// S_UP step, and an insert into an empty heap goes straight to S_PUT. A remove
// loads the last entry in S_LOAD and sinks it one level per S_DOWN step; a remove
// that empties the heap goes from S_LOAD straight to S_DONE. Each level is one
// step because the heap memory has registered read data and both children are
// read together, one on each read port. At 64 entries an entry climbs at most 6
// levels or sinks at most 5. Refused requests go straight to S_DONE. The core
// accepts the next request in the cycle after the result is loaded. A finished
// result waits in an output register and the next request stays blocked only
// until that register is free.
module min_heap_priority_queue_core
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_func,
    input  logic [KEY_W-1:0]     i_key,
    input  logic [TAG_W-1:0]     i_tag,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [KEY_W-1:0]     o_top_key,
    output logic [TAG_W-1:0]     o_top_tag,
    output logic [CNT_OUT_W-1:0] o_entry_count,
    output logic [STATUS_W-1:0]  o_status
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    t_state              r_state, n_state;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [AW-1:0]       r_pos, n_pos;
    logic [CW:0]         r_lft, n_lft;
    t_entry              r_hold, n_hold;
    logic [STATUS_W-1:0] r_status, n_status;
    t_entry              r_root, n_root;
    logic                r_out_valid, n_out_valid;
    t_entry              r_out, n_out;
    logic [CW-1:0]       r_out_cnt, n_out_cnt;
    logic [STATUS_W-1:0] r_out_status, n_out_status;

    logic                w_we;
    logic [AW-1:0]       w_waddr;
    t_entry              w_wdata;
    logic [AW-1:0]       w_raddr_a;
    logic [AW-1:0]       w_raddr_b;
    t_entry              w_rdata_a;
    t_entry              w_rdata_b;

    logic [AW-1:0]       w_up;
    logic [CW:0]         w_cnt_x;
    logic [CW:0]         w_rgt;
    logic                w_rgt_ok;
    logic                w_pick_r;
    t_entry              w_pick;
    logic [AW-1:0]       w_pick_addr;
    logic [CW:0]         w_lft2;
    logic [CW+CNT_OUT_W-1:0] w_cnt_wide;

    mhpq_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    assign w_up        = AW'(r_pos - AW'(1)) >> 1;
    assign w_cnt_x     = (CW+1)'(r_cnt);
    assign w_rgt       = r_lft + (CW+1)'(1);
    assign w_rgt_ok    = w_rgt < w_cnt_x;
    assign w_pick_r    = w_rgt_ok && !(w_rdata_a.key < w_rdata_b.key);
    assign w_pick      = w_pick_r ? w_rdata_b : w_rdata_a;
    assign w_pick_addr = w_pick_r ? w_rgt[AW-1:0] : r_lft[AW-1:0];
    assign w_lft2      = (CW+1)'({w_pick_addr, 1'b1});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_lft        <= n_lft;
        r_hold       <= n_hold;
        r_status     <= n_status;
        r_root       <= n_root;
        r_out        <= n_out;
        r_out_cnt    <= n_out_cnt;
        r_out_status <= n_out_status;
    end

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_pos        = r_pos;
        n_lft        = r_lft;
        n_hold       = r_hold;
        n_status     = r_status;
        n_out        = r_out;
        n_out_cnt    = r_out_cnt;
        n_out_status = r_out_status;
        n_out_valid  = r_out_valid && !i_out_ready;
        w_we         = 1'b0;
        w_waddr      = r_pos;
        w_wdata      = r_hold;
        w_raddr_a    = '0;
        w_raddr_b    = '0;
        o_in_ready   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                n_status   = ST_OK;
                n_hold     = '{key: i_key, tag: i_tag};
                if (i_in_valid) begin
                    if (i_func == FUNC_INSERT) begin
                        if (r_cnt == CW'(CAPACITY)) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_cnt     = r_cnt + CW'(1);
                            n_pos     = r_cnt[AW-1:0];
                            w_raddr_a = AW'(r_cnt[AW-1:0] - AW'(1)) >> 1;
                            if (r_cnt == '0) begin
                                n_state = S_PUT;
                            end else begin
                                n_state = S_UP;
                            end
                        end
                    end else begin
                        if (r_cnt == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            n_cnt     = r_cnt - CW'(1);
                            w_raddr_a = AW'(r_cnt - CW'(1));
                            n_state   = S_LOAD;
                        end
                    end
                end
            end
            S_UP: begin
                if (!(r_hold.key < w_rdata_a.key)) begin
                    w_we    = 1'b1;
                    n_state = S_DONE;
                end else begin
                    w_we      = 1'b1;
                    w_wdata   = w_rdata_a;
                    n_pos     = w_up;
                    w_raddr_a = AW'(w_up - AW'(1)) >> 1;
                    if (w_up == '0) begin
                        n_state = S_PUT;
                    end
                end
            end
            S_LOAD: begin
                n_hold    = w_rdata_a;
                n_pos     = '0;
                n_lft     = (CW+1)'(1);
                w_raddr_a = AW'(1);
                w_raddr_b = AW'(2 % CAPACITY);
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end else if (r_cnt == CW'(1)) begin
                    n_state = S_PUT;
                end else begin
                    n_state = S_DOWN;
                end
            end
            S_DOWN: begin
                w_we = 1'b1;
                if (w_pick.key < r_hold.key) begin
                    w_wdata   = w_pick;
                    n_pos     = w_pick_addr;
                    n_lft     = w_lft2;
                    w_raddr_a = w_lft2[AW-1:0];
                    w_raddr_b = AW'(w_lft2 + (CW+1)'(1));
                    if (w_lft2 >= w_cnt_x) begin
                        n_state = S_PUT;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_PUT: begin
                w_we    = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out        = (r_cnt == '0) ? '0 : r_root;
                    n_out_cnt    = r_cnt;
                    n_out_status = r_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_root = r_root;
        if (w_we && w_waddr == '0) begin
            n_root = w_wdata;
        end
    end

    assign w_cnt_wide    = {{CNT_OUT_W{1'b0}}, r_out_cnt};
    assign o_out_valid   = r_out_valid;
    assign o_top_key     = r_out.key;
    assign o_top_tag     = r_out.tag;
    assign o_entry_count = w_cnt_wide[CNT_OUT_W-1:0];
    assign o_status      = r_out_status;

endmodule
